// File: hdl/dbba_pkg.sv
// ============================================================================
// dbba_pkg: shared types and codes for the disk block bitmap allocator
// Request and response beats, the internal command word and status codes.
// ============================================================================
`default_nettype none

package dbba_pkg;

    // fixed widths of the bitmap and its counters
    localparam int MAP_BITS = 64;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;

    // response status codes
    localparam logic [2:0] ST_ALLOCATED    = 3'd0;
    localparam logic [2:0] ST_FREED        = 3'd1;
    localparam logic [2:0] ST_OUT_OF_SPACE = 3'd2;
    localparam logic [2:0] ST_FREE_FAILED  = 3'd3;
    localparam logic [2:0] ST_NOTHING      = 3'd4;

    // command opcodes between front and back
    localparam logic [1:0] OP_ALLOC    = 2'd0;
    localparam logic [1:0] OP_FREE     = 2'd1;
    localparam logic [1:0] OP_FREE_BAD = 2'd2;
    localparam logic [1:0] OP_NONE     = 2'd3;

    // request beat
    typedef struct packed {
        logic       kind;
        logic [6:0] block_count;
        logic [2:0] cylinder_in;
        logic       track_in;
        logic [1:0] record_in;
    } req_t;

    // response beat
    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  cylinder_out;
        logic        track_out;
        logic [1:0]  record_out;
        logic        last;
        logic [6:0]  blocks_free;
        logic [63:0] used_map;
    } rsp_t;

    // classified command held in the queue
    typedef struct packed {
        logic [1:0] op;
        logic [6:0] count;
        logic [2:0] cyl;
        logic       trk;
        logic [1:0] rec;
        logic [5:0] idx;
    } cmd_t;

    // front to queue write port
    typedef struct packed {
        logic push;
        cmd_t cmd;
    } push_t;

endpackage

`default_nettype wire

// File: hdl/disk_block_bitmap_allocator.sv
// ============================================================================
// disk_block_bitmap_allocator: bitmap free-space allocator top level
// Request channel (req, req_valid, req_stall) takes allocate or free beats;
// response channel (rsp, rsp_valid, rsp_stall) returns one beat per block
// allocated, or one beat for a free, an error or an empty request, each with
// last set on the final beat of the request and a snapshot of the bitmap and
// free count as they stand after that beat.
// A request enters a two-entry command queue, so up to two requests are
// taken while the engine is busy. With the engine idle, a free or an error
// beat passes through the queue entry and then the output register. An
// allocate walks the disk one block per cycle in cylinder, track, record
// order, pausing at a free block while the response is stalled, and gives
// at most one response beat per cycle; used blocks are skipped as it walks.
// Reset marks every block free and empties the queue and output register.
// While rsp_stall is high the response beat holds and the engine pauses at
// its next free block; requests are still queued until the queue is full.
// ============================================================================
`default_nettype none

module disk_block_bitmap_allocator #(
    parameter int CYLINDERS = 8,
    parameter int TRACKS    = 2,
    parameter int RECORDS   = 4
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_stall,
    input  wire dbba_pkg::req_t req,
    output logic                rsp_valid,
    input  wire                 rsp_stall,
    output dbba_pkg::rsp_t      rsp
);

    dbba_pkg::push_t wr;
    dbba_pkg::cmd_t  q_cmd;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;

    // intake and classification
    dbba_front #(
        .CYLINDERS (CYLINDERS),
        .TRACKS    (TRACKS),
        .RECORDS   (RECORDS)
    ) u_front (
        .req       (req),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .q_full    (q_full),
        .wr        (wr)
    );

    // command queue
    dbba_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .full    (q_full),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .pop     (q_pop)
    );

    // allocation engine
    dbba_back #(
        .CYLINDERS (CYLINDERS),
        .TRACKS    (TRACKS),
        .RECORDS   (RECORDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// File: hdl/dbba_front.sv
// ============================================================================
// dbba_front: request intake and classification
// Accepts request beats, sorts them into commands and computes block index.
// ============================================================================
`default_nettype none

module dbba_front #(
    parameter int CYLINDERS = 8,
    parameter int TRACKS    = 2,
    parameter int RECORDS   = 4
) (
    input  wire dbba_pkg::req_t  req,
    input  wire                  req_valid,
    output logic                 req_stall,
    input  wire                  q_full,
    output dbba_pkg::push_t      wr
);

    localparam int PER_CYL = TRACKS * RECORDS;

    logic       in_range;
    logic [5:0] blk_idx;

    // hold off while the queue is full
    assign req_stall = q_full;

    // coordinate check and linear block number
    always_comb
    begin
        in_range = ({1'b0, req.cylinder_in} < 4'(CYLINDERS)) &&
                   ({1'b0, req.track_in} < 2'(TRACKS)) &&
                   ({1'b0, req.record_in} < 3'(RECORDS));
        blk_idx  = ({3'b000, req.cylinder_in} * 6'(PER_CYL)) +
                   ({5'b00000, req.track_in} * 6'(RECORDS)) +
                   {4'b0000, req.record_in};
    end

    // classify the beat into a command
    always_comb
    begin
        wr.push      = req_valid && !q_full;
        wr.cmd.count = req.block_count;
        wr.cmd.cyl   = req.cylinder_in;
        wr.cmd.trk   = req.track_in;
        wr.cmd.rec   = req.record_in;
        wr.cmd.idx   = blk_idx;
        if (req.kind)
        begin
            wr.cmd.op = in_range ? dbba_pkg::OP_FREE : dbba_pkg::OP_FREE_BAD;
        end
        else if (req.block_count == 7'd0)
        begin
            wr.cmd.op = dbba_pkg::OP_NONE;
        end
        else
        begin
            wr.cmd.op = dbba_pkg::OP_ALLOC;
        end
    end

endmodule

`default_nettype wire

// File: hdl/dbba_queue.sv
// ============================================================================
// dbba_queue: two-entry command queue
// Decouples request intake from the allocation engine.
// ============================================================================
`default_nettype none

module dbba_queue (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire dbba_pkg::push_t wr,
    output logic                 full,
    output logic                 q_valid,
    output dbba_pkg::cmd_t       q_cmd,
    input  wire                  pop
);

    dbba_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = entry_reg[rd_ptr_reg];
    assign do_push = wr.push && !full;
    assign do_pop  = pop && q_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr.cmd;
        end
    end

endmodule

`default_nettype wire

// File: hdl/dbba_back.sv
// ============================================================================
// dbba_back: allocation engine
// Owns used bitmap, free count; allocate scans a block a cycle unless stalled.
// ============================================================================
`default_nettype none

module dbba_back #(
    parameter int CYLINDERS = 8,
    parameter int TRACKS    = 2,
    parameter int RECORDS   = 4
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 q_valid,
    input  wire dbba_pkg::cmd_t q_cmd,
    output logic                pop,
    output logic                rsp_valid,
    input  wire                 rsp_stall,
    output dbba_pkg::rsp_t      rsp
);

    localparam int BLOCKS = CYLINDERS * TRACKS * RECORDS;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic           state_reg, state_next;
    logic [63:0]    used_reg, used_next;
    logic [6:0]     free_reg, free_next;
    logic [2:0]     cyl_reg, cyl_next;
    logic           trk_reg, trk_next;
    logic [1:0]     rec_reg, rec_next;
    logic [5:0]     idx_reg, idx_next;
    logic [6:0]     remain_reg, remain_next;
    logic           out_valid_reg, out_valid_next;
    dbba_pkg::rsp_t out_reg;

    logic           emit_ok;
    logic           load;
    logic           advance;
    logic [2:0]     res_status;
    logic [2:0]     res_cyl;
    logic           res_trk;
    logic [1:0]     res_rec;
    logic           res_last;

    assign emit_ok   = !out_valid_reg || !rsp_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // command execution and scan control
    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        free_next   = free_reg;
        remain_next = remain_reg;
        pop         = 1'b0;
        load        = 1'b0;
        advance     = 1'b0;
        res_status  = dbba_pkg::ST_NOTHING;
        res_cyl     = 3'd0;
        res_trk     = 1'b0;
        res_rec     = 2'd0;
        res_last    = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_cmd.op)
                        dbba_pkg::OP_FREE,
                        dbba_pkg::OP_FREE_BAD:
                        begin
                            res_cyl = q_cmd.cyl;
                            res_trk = q_cmd.trk;
                            res_rec = q_cmd.rec;
                            if (emit_ok)
                            begin
                                pop  = 1'b1;
                                load = 1'b1;
                                if (q_cmd.op == dbba_pkg::OP_FREE && used_reg[q_cmd.idx])
                                begin
                                    used_next[q_cmd.idx] = 1'b0;
                                    free_next            = free_reg + 7'd1;
                                    res_status           = dbba_pkg::ST_FREED;
                                end
                                else
                                begin
                                    res_status = dbba_pkg::ST_FREE_FAILED;
                                end
                            end
                        end
                        dbba_pkg::OP_NONE:
                        begin
                            if (emit_ok)
                            begin
                                pop        = 1'b1;
                                load       = 1'b1;
                                res_status = dbba_pkg::ST_NOTHING;
                            end
                        end
                        dbba_pkg::OP_ALLOC:
                        begin
                            if (free_reg < q_cmd.count)
                            begin
                                if (emit_ok)
                                begin
                                    pop        = 1'b1;
                                    load       = 1'b1;
                                    res_status = dbba_pkg::ST_OUT_OF_SPACE;
                                end
                            end
                            else
                            begin
                                pop         = 1'b1;
                                state_next  = S_SCAN;
                                remain_next = q_cmd.count;
                            end
                        end
                        default:
                        begin
                            pop = 1'b0;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                res_cyl    = cyl_reg;
                res_trk    = trk_reg;
                res_rec    = rec_reg;
                res_status = dbba_pkg::ST_ALLOCATED;
                res_last   = (remain_reg == 7'd1);
                if (used_reg[idx_reg])
                begin
                    advance = 1'b1;
                end
                else if (emit_ok)
                begin
                    load               = 1'b1;
                    advance            = 1'b1;
                    used_next[idx_reg] = 1'b1;
                    free_next          = free_reg - 7'd1;
                    remain_next        = remain_reg - 7'd1;
                    if (remain_reg == 7'd1)
                    begin
                        state_next = S_IDLE;
                    end
                end
                // end of the disk closes the scan
                if (advance && idx_reg == 6'(BLOCKS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // scan position walks cylinder, track, record
    always_comb
    begin
        cyl_next = cyl_reg;
        trk_next = trk_reg;
        rec_next = rec_reg;
        idx_next = idx_reg;
        if (state_reg == S_IDLE)
        begin
            cyl_next = 3'd0;
            trk_next = 1'b0;
            rec_next = 2'd0;
            idx_next = 6'd0;
        end
        else if (advance)
        begin
            idx_next = idx_reg + 6'd1;
            if ({1'b0, rec_reg} == 3'(RECORDS - 1))
            begin
                rec_next = 2'd0;
                if ({1'b0, trk_reg} == 2'(TRACKS - 1))
                begin
                    trk_next = 1'b0;
                    cyl_next = cyl_reg + 3'd1;
                end
                else
                begin
                    trk_next = trk_reg + 1'b1;
                end
            end
            else
            begin
                rec_next = rec_reg + 2'd1;
            end
        end
    end

    // output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            free_reg      <= 7'(BLOCKS);
            cyl_reg       <= 3'd0;
            trk_reg       <= 1'b0;
            rec_reg       <= 2'd0;
            idx_reg       <= 6'd0;
            remain_reg    <= 7'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            free_reg      <= free_next;
            cyl_reg       <= cyl_next;
            trk_reg       <= trk_next;
            rec_reg       <= rec_next;
            idx_reg       <= idx_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // response beat payload, snapshot after this result
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.status       <= res_status;
            out_reg.cylinder_out <= res_cyl;
            out_reg.track_out    <= res_trk;
            out_reg.record_out   <= res_rec;
            out_reg.last         <= res_last;
            out_reg.blocks_free  <= free_next;
            out_reg.used_map     <= used_next;
        end
    end

endmodule

`default_nettype wire
